@@ src/masked_byte_pattern_search_core_defines.svh @@
// Assertion macros for the masked byte pattern search block.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef MASKED_BYTE_PATTERN_SEARCH_CORE_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define MBPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define MBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// Masked byte pattern search package
// Field widths, command codes and parameter defaults shared by the block
// and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

    // Fixed field widths.
    localparam int LEN_W    = 9;
    localparam int INDEX_W  = 8;
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 32;

    // Parameter defaults.
    localparam int DEFAULT_PATTERN_MAX = 256;
    localparam int DEFAULT_OFFSET_BITS = 32;

    // Input commands.
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_DATA    = 1'b1;

endpackage

`default_nettype wire

@@ src/mbps_ifs.sv @@
// ----------------------------------------------------------------------------
// Masked byte pattern search channels
// Valid/ready channels for input items, results and the length register.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_item_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [mbps_pkg::INDEX_W-1:0] entry_index;
    logic [mbps_pkg::BYTE_W-1:0]  byte_value;
    logic                         care;
    logic                         last;

    modport source (output valid, cmd, entry_index, byte_value, care, last, input ready);
    modport sink   (input valid, cmd, entry_index, byte_value, care, last, output ready);
endinterface

interface mbps_result_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [mbps_pkg::OFFSET_W-1:0] offset;

    modport source (output valid, found, offset, input ready);
    modport sink   (input valid, found, offset, output ready);
endinterface

interface mbps_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [mbps_pkg::LEN_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ src/masked_byte_pattern_search_core.sv @@
// ----------------------------------------------------------------------------
// Masked byte pattern search core
// Shift-and search for a byte pattern with wildcard positions over a stream.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle: a pattern entry write or one
// buffer byte. An accepted item sits in the input register, where every
// bit of the match vector is updated in parallel against the stored
// pattern, and a result (found with start offset, or not found at the end
// of a buffer) lands in the output register; a result is therefore offered
// from the output register once its byte has left the input register. The
// sustained rate of one item per cycle is set by that parallel match vector
// update and holds while the result side takes its beats; a stalled result
// holds back the input register and so the input channel. The length
// register is written through its own channel, which is always ready, and
// must only be written while the block is idle.
`default_nettype none

`include "masked_byte_pattern_search_core_defines.svh"

module masked_byte_pattern_search_core #(
    parameter int PATTERN_MAX = mbps_pkg::DEFAULT_PATTERN_MAX,
    parameter int OFFSET_BITS = mbps_pkg::DEFAULT_OFFSET_BITS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    mbps_item_if.sink           i_item,
    mbps_result_if.source       o_result,
    mbps_cfg_if.sink            i_cfg
);

    localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int DIFF_W = (OFFSET_BITS > mbps_pkg::OFFSET_W) ? OFFSET_BITS
                                                               : mbps_pkg::OFFSET_W;

    // Input register.
    logic                         r_in_vld;
    logic                         r_cmd;
    logic [mbps_pkg::INDEX_W-1:0] r_entry_index;
    logic [mbps_pkg::BYTE_W-1:0]  r_byte_value;
    logic                         r_care;
    logic                         r_last;

    // Pattern store, one cell per position.
    logic [mbps_pkg::BYTE_W-1:0]  r_pat_byte [PATTERN_MAX];
    logic                         r_pat_care [PATTERN_MAX];

    // Scan state.
    logic [PATTERN_MAX-1:0]       r_pm;
    logic [OFFSET_BITS-1:0]       r_bytes_seen;
    logic                         r_reported;
    logic [mbps_pkg::LEN_W-1:0]   r_len;

    // Output register.
    logic                          r_out_vld;
    logic                          r_found;
    logic [mbps_pkg::OFFSET_W-1:0] r_offset;

    logic                          out_free;
    logic                          fire;
    logic                          data_fire;
    logic                          scan;
    logic                          len_ok;
    logic [IDX_W-1:0]              len_m1;
    logic [IDX_W-1:0]              wr_idx;
    logic                          wr_en;
    logic [PATTERN_MAX-1:0]        upd;
    logic                          match;
    logic [DIFF_W-1:0]             start;
    logic [PATTERN_MAX-1:0]        n_pm;
    logic [OFFSET_BITS-1:0]        n_bytes_seen;
    logic                          n_reported;
    logic                          n_out_load;

    assign out_free  = !r_out_vld || o_result.ready;
    assign fire      = r_in_vld && out_free;
    assign data_fire = fire && (r_cmd == mbps_pkg::CMD_DATA);
    assign scan      = data_fire && !r_reported;

    assign i_item.ready = !r_in_vld || fire;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid  = r_out_vld;
    assign o_result.found  = r_found;
    assign o_result.offset = r_offset;

    // Lengths above the pattern store behave like zero: never a match.
    assign len_ok = (r_len != '0) && (32'(r_len) <= PATTERN_MAX);
    assign len_m1 = IDX_W'(r_len - mbps_pkg::LEN_W'(1));

    assign wr_idx = IDX_W'(r_entry_index);
    assign wr_en  = fire && (r_cmd == mbps_pkg::CMD_PATTERN)
                    && (32'(r_entry_index) < PATTERN_MAX);

    // Each position extends the partial match of the one below it; positions
    // beyond the current length keep their old bits.
    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            logic hit;
            logic prev;
            hit  = !r_pat_care[k] || (r_pat_byte[k] == r_byte_value);
            prev = (k == 0) ? 1'b1 : r_pm[(k == 0) ? 0 : k - 1];
            upd[k] = (32'(r_len) > k) ? (prev && hit) : r_pm[k];
        end
    end

    assign match = len_ok && upd[len_m1];

    // Worked out at a width of at least 32 bits so that the offset wraps
    // exactly as a 32-bit start offset would.
    assign start = DIFF_W'(r_bytes_seen) - DIFF_W'(r_len - mbps_pkg::LEN_W'(1));

    always_comb begin
        n_pm         = r_pm;
        n_bytes_seen = r_bytes_seen;
        n_reported   = r_reported;
        n_out_load   = scan && (match || r_last);
        if (scan && len_ok) begin
            n_pm = upd;
        end
        if (scan && match) begin
            n_reported = 1'b1;
        end
        if (data_fire) begin
            if (r_bytes_seen != '1) begin
                n_bytes_seen = r_bytes_seen + OFFSET_BITS'(1);
            end
            if (r_last) begin
                n_pm         = '0;
                n_bytes_seen = '0;
                n_reported   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_pm         <= '0;
            r_bytes_seen <= '0;
            r_reported   <= 1'b0;
            r_len        <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_item.valid && i_item.ready) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            r_pm         <= n_pm;
            r_bytes_seen <= n_bytes_seen;
            r_reported   <= n_reported;
            if (i_cfg.valid && i_cfg.ready) begin
                r_len <= i_cfg.data;
            end
            if (n_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_cmd         <= i_item.cmd;
            r_entry_index <= i_item.entry_index;
            r_byte_value  <= i_item.byte_value;
            r_care        <= i_item.care;
            r_last        <= i_item.last;
        end
        if (n_out_load) begin
            r_found  <= match;
            r_offset <= match ? mbps_pkg::OFFSET_W'(start) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pat_byte[wr_idx] <= r_byte_value;
            r_pat_care[wr_idx] <= r_care;
        end
    end

    `MBPS_ASSERT_IMPL(a_not_found_zero, r_out_vld && !r_found, r_offset == '0, "not-found result with non-zero offset")
    `MBPS_ASSERT_IMPL(a_result_from_data, n_out_load, r_cmd == mbps_pkg::CMD_DATA, "result raised by a pattern write")
    `MBPS_ASSERT_NEXT(a_last_clears, data_fire && r_last, (r_pm == '0) && (r_bytes_seen == '0) && !r_reported, "scan state not cleared after last byte")
    `MBPS_ASSERT_NEXT(a_count_grows, data_fire && !r_last, r_bytes_seen >= $past(r_bytes_seen), "byte counter went backwards within a buffer")

endmodule

`default_nettype wire
